// File: design/msma_pkg.sv
`timescale 1ns / 1ps

package msma_pkg;

    localparam int WINDOW      = 8;
    localparam int NUM_SENSORS = 4;
    localparam int NUM_LANES   = 3;
    localparam int SAMPLE_W    = 16;

    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RING_DEPTH  = NUM_SENSORS * WINDOW;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);

    localparam int RECIP_SHIFT = SUM_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int Q_W         = SAMPLE_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / WINDOW);

    typedef logic [1:0] sensor_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sensor_t ID_GYRO = 2'd0;
    localparam sensor_t ID_MAG  = 2'd1;
    localparam sensor_t ID_BARO = 2'd2;
    localparam sensor_t ID_HALL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SCALE,
        ST_FIX,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              upd_en;
        logic              scale_en;
        logic              fix_en;
        logic              active;
        sensor_t           sensor;
        logic [SLOT_W-1:0] slot;
        logic              wrapped;
    } lane_ctrl_t;

endpackage

// File: design/msma_lane.sv
`timescale 1ns / 1ps

module msma_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msma_pkg::lane_ctrl_t ctrl,
    input  msma_pkg::sample_t    sample,
    output msma_pkg::sample_t    level
);

    msma_pkg::sample_t ring_mem [msma_pkg::RING_DEPTH];

    logic signed [msma_pkg::SUM_W-1:0] sum_reg [msma_pkg::NUM_SENSORS];
    logic signed [msma_pkg::SUM_W-1:0] sum_next;
    logic signed [msma_pkg::SUM_W-1:0] old_val;
    logic [msma_pkg::ADDR_W-1:0]       addr;
    logic [msma_pkg::SUM_W-1:0]        mag_next;
    logic [msma_pkg::PROD_W-1:0]       prod;
    logic [msma_pkg::SUM_W-1:0]        rem;
    logic [msma_pkg::Q_W-1:0]          q_fixed;
    logic [msma_pkg::Q_W-1:0]          q_signed;

    msma_pkg::sample_t          rd_data_reg;
    logic [msma_pkg::SUM_W-1:0] mag_reg;
    logic                       neg_reg;
    logic [msma_pkg::Q_W-1:0]   qest_reg;
    msma_pkg::sample_t          level_reg;

    assign addr = msma_pkg::ADDR_W'(msma_pkg::ADDR_W'(ctrl.sensor)
                  * msma_pkg::ADDR_W'(msma_pkg::WINDOW)
                  + msma_pkg::ADDR_W'(ctrl.slot));

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= ring_mem[addr];
        end
        if (ctrl.upd_en && ctrl.active) begin
            ring_mem[addr] <= sample;
        end
    end

    // Entries of a ring that has not wrapped yet were never written and count as zero.
    always_comb begin
        old_val  = ctrl.wrapped ? msma_pkg::SUM_W'(rd_data_reg) : '0;
        sum_next = sum_reg[ctrl.sensor] - old_val + msma_pkg::SUM_W'(sample);
        mag_next = sum_next[msma_pkg::SUM_W-1] ? msma_pkg::SUM_W'(-sum_next)
                                               : msma_pkg::SUM_W'(sum_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msma_pkg::NUM_SENSORS; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (ctrl.upd_en && ctrl.active) begin
            sum_reg[ctrl.sensor] <= sum_next;
        end
    end

    // The reciprocal estimate is at most one below the true quotient; one step fixes it.
    always_comb begin
        prod     = msma_pkg::PROD_W'(mag_reg) * msma_pkg::PROD_W'(msma_pkg::RECIP);
        rem      = mag_reg - msma_pkg::SUM_W'(qest_reg) * msma_pkg::SUM_W'(msma_pkg::WINDOW);
        q_fixed  = (rem >= msma_pkg::SUM_W'(msma_pkg::WINDOW)) ? qest_reg + 1'b1 : qest_reg;
        q_signed = neg_reg ? msma_pkg::Q_W'(-q_fixed) : q_fixed;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd_en) begin
            mag_reg <= mag_next;
            neg_reg <= sum_next[msma_pkg::SUM_W-1];
        end
        if (ctrl.scale_en) begin
            qest_reg <= msma_pkg::Q_W'(prod >> msma_pkg::RECIP_SHIFT);
        end
        if (ctrl.fix_en) begin
            level_reg <= q_signed[msma_pkg::SAMPLE_W-1:0];
        end
    end

    assign level = level_reg;

endmodule

// File: design/msma_merge.sv
`timescale 1ns / 1ps

module msma_merge (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  msma_pkg::sensor_t      sensor,
    input  logic                   smooth,
    input  msma_pkg::sample_t      samples [msma_pkg::NUM_LANES],
    input  msma_pkg::sample_t      levels  [msma_pkg::NUM_LANES],
    output logic                   load_ok,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata
);

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [47:0]          m_tdata_reg;
    msma_pkg::sample_t    merged [msma_pkg::NUM_LANES];
    logic                 three_ch;

    always_comb begin
        three_ch = sensor inside {msma_pkg::ID_GYRO, msma_pkg::ID_MAG};
        for (int c = 0; c < msma_pkg::NUM_LANES; c++) begin
            if (c == msma_pkg::NUM_LANES - 1 && !three_ch) begin
                merged[c] = '0;
            end else if (smooth) begin
                merged[c] = levels[c];
            end else begin
                merged[c] = samples[c];
            end
        end
    end

    assign load_ok = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {merged[2], merged[1], merged[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/multi_sensor_moving_average_unit.sv
`timescale 1ns / 1ps

// Boxcar smoothing for four sensors (gyro and magnetometer with three channels, barometer and
// hall with two). Each request carries one sample set; the samples go into that sensor's rings
// and, when the sensor's bit in smooth_enable is set, each channel returns its ring sum divided
// by the window and truncated toward zero, otherwise the raw samples. Three lanes, one per
// channel position, keep a running sum and a ring memory each; a sequencer takes an item through
// ring read, sum update, reciprocal scaling, correction and output load, and takes no new item
// before that one has been loaded. The output register lets a new request enter while the
// previous result waits. No clearing pass follows reset: per-sensor wrap flags make
// never-written ring entries count as zero.
module multi_sensor_moving_average_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,  // smooth_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // sample_0, sample_1, sample_2
    input  logic [1:0]  s_tuser,      // sensor_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata       // level_0, level_1, level_2
);

    msma_pkg::state_t state_reg;
    msma_pkg::state_t state_next;

    logic [3:0]                     smooth_reg;
    msma_pkg::sensor_t              sensor_reg;
    msma_pkg::sample_t              sample_reg [msma_pkg::NUM_LANES];
    logic [msma_pkg::SLOT_W-1:0]    slot_reg;
    logic                           wrapped_reg;
    logic [msma_pkg::SLOT_W-1:0]    write_slot_reg [msma_pkg::NUM_SENSORS];
    logic [msma_pkg::NUM_SENSORS-1:0] wrapped_flags_reg;

    logic                 accept;
    logic                 load_ok;
    logic                 emit_load;
    logic                 three_ch;
    logic                 slot_last;
    msma_pkg::lane_ctrl_t ctrl_base;
    msma_pkg::lane_ctrl_t lane_ctrl [msma_pkg::NUM_LANES];
    msma_pkg::sample_t    lane_level [msma_pkg::NUM_LANES];

    assign accept    = s_tvalid && s_tready;
    assign slot_last = (slot_reg == msma_pkg::SLOT_W'(msma_pkg::WINDOW - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = msma_pkg::ST_READ;
                end
            end
            msma_pkg::ST_READ:   state_next = msma_pkg::ST_UPDATE;
            msma_pkg::ST_UPDATE: state_next = msma_pkg::ST_SCALE;
            msma_pkg::ST_SCALE:  state_next = msma_pkg::ST_FIX;
            msma_pkg::ST_FIX:    state_next = msma_pkg::ST_EMIT;
            msma_pkg::ST_EMIT: begin
                if (load_ok) begin
                    state_next = msma_pkg::ST_IDLE;
                end
            end
            default: state_next = msma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready           = 1'b0;
        emit_load          = 1'b0;
        ctrl_base.rd_en    = 1'b0;
        ctrl_base.upd_en   = 1'b0;
        ctrl_base.scale_en = 1'b0;
        ctrl_base.fix_en   = 1'b0;
        ctrl_base.active   = 1'b1;
        ctrl_base.sensor   = sensor_reg;
        ctrl_base.slot     = slot_reg;
        ctrl_base.wrapped  = wrapped_reg;
        case (state_reg)
            msma_pkg::ST_IDLE:   s_tready = 1'b1;
            msma_pkg::ST_READ:   ctrl_base.rd_en = 1'b1;
            msma_pkg::ST_UPDATE: ctrl_base.upd_en = 1'b1;
            msma_pkg::ST_SCALE:  ctrl_base.scale_en = 1'b1;
            msma_pkg::ST_FIX:    ctrl_base.fix_en = 1'b1;
            msma_pkg::ST_EMIT:   emit_load = load_ok;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msma_pkg::ST_IDLE;
            smooth_reg  <= 4'd6;
            wrapped_flags_reg <= '0;
            for (int i = 0; i < msma_pkg::NUM_SENSORS; i++) begin
                write_slot_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                smooth_reg <= cfg_wr_data;
            end
            if (state_reg == msma_pkg::ST_READ) begin
                write_slot_reg[sensor_reg] <= slot_last ? '0 : slot_reg + 1'b1;
                if (slot_last) begin
                    wrapped_flags_reg[sensor_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sensor_reg    <= s_tuser;
            sample_reg[0] <= s_tdata[15:0];
            sample_reg[1] <= s_tdata[31:16];
            sample_reg[2] <= s_tdata[47:32];
            slot_reg      <= write_slot_reg[s_tuser];
            wrapped_reg   <= wrapped_flags_reg[s_tuser];
        end
    end

    assign three_ch = sensor_reg inside {msma_pkg::ID_GYRO, msma_pkg::ID_MAG};

    for (genvar g = 0; g < msma_pkg::NUM_LANES; g++) begin : g_lane
        always_comb begin
            lane_ctrl[g]        = ctrl_base;
            lane_ctrl[g].active = (g < msma_pkg::NUM_LANES - 1) ? 1'b1 : three_ch;
        end

        msma_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl[g]),
            .sample  (sample_reg[g]),
            .level   (lane_level[g])
        );
    end

    msma_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit_load),
        .sensor   (sensor_reg),
        .smooth   (smooth_reg[sensor_reg]),
        .samples  (sample_reg),
        .levels   (lane_level),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
